// File: rtl/ctsa_pkg.sv
// Shared constants, control-word types, microcode ROM and tile lookup functions.
package ctsa_pkg;

  localparam int unsigned NSLOT     = 9;
  localparam int unsigned DEF_RINGS = 4;
  localparam int unsigned RING_W    = 3;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned TILE_W    = 4;
  localparam int unsigned CELL_W    = 32;
  localparam int unsigned ORIG_W    = 33;
  localparam int unsigned TSIZE_W   = 24;
  localparam int unsigned BASE_W    = 16;
  // 65535 * 3^6 still fits, so any ring count up to seven is exact
  localparam int unsigned SIZE_W    = 26;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned PC_W      = 3;

  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(256);

  localparam int unsigned IN_DATA_W  = 2 * CELL_W;
  localparam int unsigned OUT_BITS   = RING_W + SLOT_W + TILE_W + 2 * CELL_W + 2 * ORIG_W
                                       + TSIZE_W;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - OUT_BITS;

  localparam logic [CNT_W-1:0] CNT_NSLOT = CNT_W'(NSLOT);
  localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(NSLOT - 1);

  // microprogram step addresses
  localparam logic [PC_W-1:0] PC_IDLE    = 3'd0;
  localparam logic [PC_W-1:0] PC_RING    = 3'd1;
  localparam logic [PC_W-1:0] PC_DIV     = 3'd2;
  localparam logic [PC_W-1:0] PC_MATCH   = 3'd3;
  localparam logic [PC_W-1:0] PC_ALLOC   = 3'd4;
  localparam logic [PC_W-1:0] PC_EMIT_RD = 3'd5;
  localparam logic [PC_W-1:0] PC_EMIT_LD = 3'd6;
  localparam logic [PC_W-1:0] PC_NEXT    = 3'd7;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_DIV_START,
    OP_DIV_WAIT,
    OP_MATCH,
    OP_ALLOC,
    OP_EMIT_RD,
    OP_EMIT_LD,
    OP_NEXT_RING
  } op_e;

  typedef enum logic [1:0] {
    H_NONE,
    H_NO_INPUT,
    H_DIV_BUSY,
    H_OUT_BLOCKED
  } hold_e;

  typedef enum logic [1:0] {
    J_NONE,
    J_MATCH_RUN,
    J_CNT_MORE,
    J_RING_MORE
  } jump_e;

  typedef struct packed {
    op_e              op;
    hold_e            hold;
    jump_e            jump;
    logic [PC_W-1:0]  tgt;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic div_busy;
    logic out_blocked;
    logic match_run;
    logic cnt_more;
    logic ring_more;
  } stat_t;

  // Step ROM. Hold keeps the step, else a taken jump goes to tgt, else pc+1.
  // The last step falls through by wrapping back to PC_IDLE.
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = '{op: OP_IDLE, hold: H_NO_INPUT, jump: J_NONE, tgt: PC_IDLE};
    case (pc)
      PC_IDLE:    w = '{op: OP_IDLE,      hold: H_NO_INPUT,    jump: J_NONE,      tgt: PC_IDLE};
      PC_RING:    w = '{op: OP_DIV_START, hold: H_NONE,        jump: J_NONE,      tgt: PC_IDLE};
      PC_DIV:     w = '{op: OP_DIV_WAIT,  hold: H_DIV_BUSY,    jump: J_NONE,      tgt: PC_IDLE};
      PC_MATCH:   w = '{op: OP_MATCH,     hold: H_NONE,        jump: J_MATCH_RUN, tgt: PC_MATCH};
      PC_ALLOC:   w = '{op: OP_ALLOC,     hold: H_NONE,        jump: J_CNT_MORE,  tgt: PC_ALLOC};
      PC_EMIT_RD: w = '{op: OP_EMIT_RD,   hold: H_NONE,        jump: J_NONE,      tgt: PC_IDLE};
      PC_EMIT_LD: w = '{op: OP_EMIT_LD,   hold: H_OUT_BLOCKED, jump: J_CNT_MORE,
                        tgt: PC_EMIT_RD};
      PC_NEXT:    w = '{op: OP_NEXT_RING, hold: H_NONE,        jump: J_RING_MORE, tgt: PC_RING};
      default:    w = '{op: OP_IDLE,      hold: H_NO_INPUT,    jump: J_NONE,      tgt: PC_IDLE};
    endcase
    return w;
  endfunction

  // neighbour offset codes: 0 is -1, 1 is 0, 2 is +1
  function automatic logic [TILE_W-1:0] offs_tile(input logic [1:0] ox, input logic [1:0] oy);
    logic [TILE_W-1:0] t;
    case ({ox, oy})
      4'b0000: t = 4'd1;
      4'b0001: t = 4'd4;
      4'b0010: t = 4'd6;
      4'b0100: t = 4'd2;
      4'b0101: t = 4'd0;
      4'b0110: t = 4'd7;
      4'b1000: t = 4'd3;
      4'b1001: t = 4'd5;
      4'b1010: t = 4'd8;
      default: t = 4'd0;
    endcase
    return t;
  endfunction

  function automatic logic [1:0] tile_dx(input logic [TILE_W-1:0] tid);
    logic [1:0] c;
    case (tid)
      4'd1, 4'd4, 4'd6: c = 2'd0;
      4'd3, 4'd5, 4'd8: c = 2'd2;
      default:          c = 2'd1;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] tile_dy(input logic [TILE_W-1:0] tid);
    logic [1:0] c;
    case (tid)
      4'd1, 4'd2, 4'd3: c = 2'd0;
      4'd6, 4'd7, 4'd8: c = 2'd2;
      default:          c = 2'd1;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/ctsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ctsa_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 36
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/ctsa_div.sv
// Iterative restoring divider, one quotient bit per cycle, floor rounding.
module ctsa_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ctsa_pkg::CELL_W-1:0]  dividend_i,
  input  logic [ctsa_pkg::SIZE_W-1:0]  divisor_i,
  output logic                         busy_o,
  output logic [ctsa_pkg::CELL_W-1:0]  quotient_o
);
  import ctsa_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIX  = 2'd2;
  localparam int unsigned ITER_W = $clog2(CELL_W);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CELL_W - 1);

  logic [1:0]        state_q, state_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic              neg_q, neg_d;
  logic [SIZE_W-1:0] rem_q, rem_d;
  logic [SIZE_W-1:0] div_q, div_d;
  logic [CELL_W-1:0] quo_q, quo_d;
  logic [SIZE_W:0]   shifted;
  logic [SIZE_W:0]   diff;

  assign shifted = {rem_q, quo_q[CELL_W-1]};
  assign diff    = shifted - {1'b0, div_q};

  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    neg_d   = neg_q;
    rem_d   = rem_q;
    div_d   = div_q;
    quo_d   = quo_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          neg_d   = dividend_i[CELL_W-1];
          quo_d   = dividend_i[CELL_W-1] ? (~dividend_i + 1'b1) : dividend_i;
          rem_d   = '0;
          div_d   = divisor_i;
          iter_d  = '0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (shifted >= {1'b0, div_q}) begin
          rem_d = diff[SIZE_W-1:0];
          quo_d = {quo_q[CELL_W-2:0], 1'b1};
        end else begin
          rem_d = shifted[SIZE_W-1:0];
          quo_d = {quo_q[CELL_W-2:0], 1'b0};
        end
        iter_d = iter_q + 1'b1;
        if (iter_q == ITER_LAST) begin
          state_d = ST_FIX;
        end
      end
      ST_FIX: begin
        // negative with a remainder rounds down: -(q+1) is ~q
        if (neg_q) begin
          quo_d = (rem_q != '0) ? ~quo_q : (~quo_q + 1'b1);
        end
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    rem_q <= rem_d;
    div_q <= div_d;
    quo_q <= quo_d;
  end

  assign busy_o     = (state_q != ST_IDLE);
  assign quotient_o = quo_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == ST_IDLE)
    else $error("divider started while busy");

endmodule

// File: rtl/ctsa_seq.sv
// Microcode sequencer: step counter, control ROM, hold and jump logic.
module ctsa_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctsa_pkg::stat_t   stat_i,
  output ctsa_pkg::ctrl_t   ctrl_o
);
  import ctsa_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;
  ctrl_t           word;
  logic            hold;
  logic            jump;

  assign word = ucode(pc_q);

  always_comb begin
    case (word.hold)
      H_NONE:        hold = 1'b0;
      H_NO_INPUT:    hold = !stat_i.in_valid;
      H_DIV_BUSY:    hold = stat_i.div_busy;
      H_OUT_BLOCKED: hold = stat_i.out_blocked;
      default:       hold = 1'b0;
    endcase
    case (word.jump)
      J_NONE:      jump = 1'b0;
      J_MATCH_RUN: jump = stat_i.match_run;
      J_CNT_MORE:  jump = stat_i.cnt_more;
      J_RING_MORE: jump = stat_i.ring_more;
      default:     jump = 1'b0;
    endcase
    if (hold) begin
      pc_d = pc_q;
    end else if (jump) begin
      pc_d = word.tgt;
    end else begin
      pc_d = pc_q + PC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = word;

endmodule

// File: rtl/clipmap_tile_slot_assigner.sv
// Clipmap tile slot assigner: per-ring centre cell, slot reuse and allocation.
//
// Input stream (s_axis_*): one word per viewer position, pos_x and pos_y.
// Output stream (m_axis_*): nine words per ring, ring-major then slot order,
// RINGS*9 words per position; tlast marks the final word, tuser flags a slot
// that was newly assigned and needs its texture regenerated.
// APB port: one register, tile_base_size at address 0 (0 acts as 1).
// A position is taken only while the block is idle. Each ring runs two
// 32-step dividers in parallel, a slot match pass over the slot RAM, an
// allocation pass over the nine tiles, and then a read step and a load step
// for each emitted word; the next position is taken only after the last
// ring has been emitted. The dividers account for most of the delay before
// the first word appears.
// Results sit in one output register; a stalled receiver holds the
// sequencer on its load step and nothing is lost or repeated.
// Reset marks every slot empty and sets the base size to 256; slot cells
// live in a RAM that needs no clearing.
module clipmap_tile_slot_assigner #(
  parameter int unsigned RINGS = ctsa_pkg::DEF_RINGS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [ctsa_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // pos_x, pos_y
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // ring_index, slot_index, tile_id, cell_x, cell_y, origin_x, origin_y, tile_size, pad
  output logic [ctsa_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tuser,   // needs_compute
  output logic                              m_axis_tlast,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import ctsa_pkg::*;

  localparam int unsigned DEPTH  = RINGS * NSLOT;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam logic [RING_W-1:0] RING_LAST = RING_W'(RINGS - 1);

  ctrl_t ctrl;
  stat_t stat;

  logic [BASE_W-1:0] base_q, base_d;
  logic [CELL_W-1:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [RING_W-1:0] ring_q, ring_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DEPTH-1:0]  slot_valid_q, slot_valid_d;
  logic [NSLOT-1:0]  tile_has_q, tile_has_d;
  logic [NSLOT-1:0]  taken_q, taken_d;
  logic [NSLOT-1:0]  fresh_q, fresh_d;
  logic [TILE_W-1:0] slot_tile_q [NSLOT];
  logic [TILE_W-1:0] slot_tile_d [NSLOT];
  logic              out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic              out_user_q, out_user_d;
  logic              out_last_q, out_last_d;

  logic              cfg_we;
  logic              in_acc;
  logic              div_start;
  logic              busy_x, busy_y;
  logic [CELL_W-1:0] cx, cy;

  logic [ADDR_W-1:0] ring_base;
  logic [CNT_W-1:0]  rd_slot;
  logic [ADDR_W-1:0] rd_addr;
  logic [2*CELL_W-1:0] rd_data;
  logic [CELL_W-1:0] rd_x, rd_y;

  logic [CELL_W-1:0] diff_x, diff_y;
  logic [1:0]        code_x, code_y;
  logic              near_x, near_y;
  logic [CNT_W-1:0]  m_slot;
  logic [ADDR_W-1:0] m_addr;
  logic              match_hit;
  logic [TILE_W-1:0] m_tid;

  logic [CNT_W-1:0]  a_free;
  logic              a_any;
  logic              alloc_hit;
  logic [ADDR_W-1:0] a_addr;
  logic [2*CELL_W-1:0] a_wdata;

  logic              emit_ld;
  logic signed [CELL_W+SIZE_W:0] prod_x, prod_y;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign base_d = cfg_we ? pwdata[BASE_W-1:0] : base_q;
  assign prdata = (paddr[2] == 1'b0) ? {{(32 - BASE_W){1'b0}}, base_q} : 32'd0;

  // ---------------- sequencer and dividers ----------------
  ctsa_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  assign div_start = (ctrl.op == OP_DIV_START);

  ctsa_div u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (pos_x_q),
    .divisor_i  (size_q),
    .busy_o     (busy_x),
    .quotient_o (cx)
  );

  ctsa_div u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (pos_y_q),
    .divisor_i  (size_q),
    .busy_o     (busy_y),
    .quotient_o (cy)
  );

  assign s_axis_tready = (ctrl.op == OP_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign stat.in_valid    = s_axis_tvalid;
  assign stat.div_busy    = busy_x || busy_y;
  assign stat.out_blocked = out_valid_q && !m_axis_tready;
  assign stat.match_run   = (cnt_q != CNT_NSLOT);
  assign stat.cnt_more    = (cnt_q != CNT_LAST);
  assign stat.ring_more   = (ring_q != RING_LAST);

  // ---------------- slot cell RAM ----------------
  assign ring_base = ADDR_W'({ring_q, 3'b000}) + ADDR_W'(ring_q);
  assign rd_slot   = (cnt_q == CNT_NSLOT) ? '0 : cnt_q;
  assign rd_addr   = ring_base + ADDR_W'(rd_slot);

  ctsa_ram #(
    .WIDTH (2 * CELL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (alloc_hit),
    .waddr_i (a_addr),
    .wdata_i (a_wdata),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign rd_x = rd_data[CELL_W-1:0];
  assign rd_y = rd_data[2*CELL_W-1:CELL_W];

  // ---------------- match: data read last cycle belongs to slot cnt-1 ----------------
  assign diff_x = rd_x - cx;
  assign diff_y = rd_y - cy;

  always_comb begin
    near_x = 1'b1;
    code_x = 2'd1;
    if (diff_x == '1) begin
      code_x = 2'd0;
    end else if (diff_x == CELL_W'(1)) begin
      code_x = 2'd2;
    end else if (diff_x != '0) begin
      near_x = 1'b0;
    end
    near_y = 1'b1;
    code_y = 2'd1;
    if (diff_y == '1) begin
      code_y = 2'd0;
    end else if (diff_y == CELL_W'(1)) begin
      code_y = 2'd2;
    end else if (diff_y != '0) begin
      near_y = 1'b0;
    end
  end

  assign m_slot    = cnt_q - 1'b1;
  assign m_addr    = ring_base + ADDR_W'(m_slot);
  assign m_tid     = offs_tile(code_x, code_y);
  assign match_hit = (ctrl.op == OP_MATCH) && (cnt_q != '0) && slot_valid_q[m_addr]
                     && near_x && near_y;

  // ---------------- allocation: tile cnt goes to the lowest free slot ----------------
  always_comb begin
    a_free = '0;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (!taken_q[i]) begin
        a_free = CNT_W'(i);
      end
    end
  end

  assign a_any     = !(&taken_q);
  assign alloc_hit = (ctrl.op == OP_ALLOC) && !tile_has_q[cnt_q] && a_any;
  assign a_addr    = ring_base + ADDR_W'(a_free);
  assign a_wdata   = {cy + CELL_W'(tile_dy(cnt_q)) - CELL_W'(1),
                      cx + CELL_W'(tile_dx(cnt_q)) - CELL_W'(1)};

  // ---------------- emission ----------------
  assign emit_ld = (ctrl.op == OP_EMIT_LD) && !stat.out_blocked;
  assign prod_x  = $signed(rd_x) * $signed({1'b0, size_q});
  assign prod_y  = $signed(rd_y) * $signed({1'b0, size_q});

  always_comb begin
    pos_x_d      = pos_x_q;
    pos_y_d      = pos_y_q;
    size_d       = size_q;
    ring_d       = ring_q;
    cnt_d        = cnt_q;
    slot_valid_d = slot_valid_q;
    tile_has_d   = tile_has_q;
    taken_d      = taken_q;
    fresh_d      = fresh_q;
    slot_tile_d  = slot_tile_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_data_d   = out_data_q;
    out_user_d   = out_user_q;
    out_last_d   = out_last_q;

    case (ctrl.op)
      OP_IDLE: begin
        if (in_acc) begin
          pos_x_d = s_axis_tdata[CELL_W-1:0];
          pos_y_d = s_axis_tdata[2*CELL_W-1:CELL_W];
          size_d  = (base_q == '0) ? SIZE_W'(1) : SIZE_W'(base_q);
          ring_d  = '0;
          cnt_d   = '0;
        end
      end
      OP_DIV_START: begin
        tile_has_d = '0;
        taken_d    = '0;
        fresh_d    = '0;
        for (int i = 0; i < NSLOT; i++) begin
          slot_tile_d[i] = '0;
        end
        cnt_d = '0;
      end
      OP_MATCH: begin
        if (match_hit) begin
          tile_has_d[m_tid]   = 1'b1;
          taken_d[m_slot]     = 1'b1;
          slot_tile_d[m_slot] = m_tid;
        end
        cnt_d = stat.match_run ? cnt_q + 1'b1 : '0;
      end
      OP_ALLOC: begin
        if (alloc_hit) begin
          tile_has_d[cnt_q]   = 1'b1;
          taken_d[a_free]     = 1'b1;
          fresh_d[a_free]     = 1'b1;
          slot_tile_d[a_free] = cnt_q;
          slot_valid_d[a_addr] = 1'b1;
        end
        cnt_d = stat.cnt_more ? cnt_q + 1'b1 : '0;
      end
      OP_EMIT_LD: begin
        if (emit_ld) begin
          out_valid_d = 1'b1;
          out_data_d  = {{OUT_PAD_W{1'b0}}, size_q[TSIZE_W-1:0],
                         prod_y[ORIG_W-1:0], prod_x[ORIG_W-1:0], rd_y, rd_x,
                         slot_tile_q[cnt_q], cnt_q, ring_q};
          out_user_d  = fresh_q[cnt_q];
          out_last_d  = (ring_q == RING_LAST) && (cnt_q == CNT_LAST);
          cnt_d       = stat.cnt_more ? cnt_q + 1'b1 : '0;
        end
      end
      OP_NEXT_RING: begin
        if (stat.ring_more) begin
          ring_d = ring_q + 1'b1;
          size_d = size_q + {size_q[SIZE_W-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q       <= BASE_RESET;
      ring_q       <= '0;
      cnt_q        <= '0;
      slot_valid_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      base_q       <= base_d;
      ring_q       <= ring_d;
      cnt_q        <= cnt_d;
      slot_valid_q <= slot_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_x_q     <= pos_x_d;
    pos_y_q     <= pos_y_d;
    size_q      <= size_d;
    tile_has_q  <= tile_has_d;
    taken_q     <= taken_d;
    fresh_q     <= fresh_d;
    slot_tile_q <= slot_tile_d;
    out_data_q  <= out_data_d;
    out_user_q  <= out_user_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

  a_last_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |->
      (m_axis_tdata[RING_W-1:0] == RING_LAST)
      && (m_axis_tdata[RING_W+SLOT_W-1:RING_W] == CNT_LAST))
    else $error("tlast on a word that is not the final slot of the final ring");

  a_ring_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == OP_NEXT_RING) |-> (&taken_q))
    else $error("ring finished with a slot left unassigned");

  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == OP_EMIT_LD) |-> slot_valid_q[rd_addr])
    else $error("emitting a slot that was never written");

  a_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !stat.div_busy)
    else $error("input taken while a division is running");

endmodule
